>>> design/bitmap_glyph_row_renderer_core_assert.svh
// Assertion macros for the glyph row renderer.
// Both take a label, an antecedent and a consequent; clk and rst_n are
// taken from the module that uses them.
`ifndef BITMAP_GLYPH_ROW_RENDERER_CORE_ASSERT_SVH
`define BITMAP_GLYPH_ROW_RENDERER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define BGR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bgr: same-cycle check failed");
`define BGR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bgr: next-cycle check failed");
`else
`define BGR_ASSERT_IMP(label, ante, cons)
`define BGR_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> design/bgr_pkg.sv
`timescale 1ns / 1ps

package bgr_pkg;

  // Wide enough for glyph base plus 32 rows of the largest stride.
  localparam int ADDR_W = 18;

  typedef logic [ADDR_W-1:0] addr_t;

  localparam int DEF_FONT_BYTES       = 32768;
  localparam int DEF_MAX_GLYPH_WIDTH  = 32;
  localparam int DEF_MAX_GLYPH_HEIGHT = 32;

  localparam addr_t      TABLE_PTR_ADDR  = addr_t'(15);
  localparam logic [7:0] LAST_PLAIN_CODE = 8'd127;
  localparam logic [6:0] FALLBACK_CODE   = 7'd63;

  localparam int ROW_BITS = 32;

  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_INK   = 1'b1;

endpackage

>>> design/bgr_font_mem.sv
`timescale 1ns / 1ps

module bgr_font_mem import bgr_pkg::*; #(
  parameter int FONT_BYTES = DEF_FONT_BYTES
) (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [14:0] wr_addr,
  input  logic [7:0]  wr_data,
  input  addr_t       rd_addr,
  output logic [7:0]  rd_data
);

  localparam int    IDX_W = $clog2(FONT_BYTES);
  localparam addr_t LIMIT = addr_t'(FONT_BYTES);

  logic [7:0] mem [FONT_BYTES];
  logic [7:0] rd_q_r;
  logic       in_range_r;

  always_ff @(posedge clk) begin
    if (wr_en && (addr_t'(wr_addr) < LIMIT)) begin
      mem[wr_addr[IDX_W-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_q_r     <= mem[rd_addr[IDX_W-1:0]];
    in_range_r <= rd_addr < LIMIT;
  end

  // bytes beyond the store read as zero
  assign rd_data = in_range_r ? rd_q_r : 8'd0;

endmodule

>>> design/bgr_adder.sv
`timescale 1ns / 1ps

// Address adder shared by pointer chasing, byte stepping and row stride.
module bgr_adder import bgr_pkg::*; (
  input  addr_t a,
  input  addr_t b,
  output addr_t sum
);

  assign sum = a + b;

endmodule

>>> design/bitmap_glyph_row_renderer_core.sv
`timescale 1ns / 1ps
`include "bitmap_glyph_row_renderer_core_assert.svh"

// Bitmap glyph row renderer. Font bytes are loaded by write transfers into
// a byte store with one write port and a registered read port; the store
// has no reset and is not cleared. A draw transfer chases the table
// pointer at byte 15, the glyph pointer, then glyph width and height: four
// 16-bit reads, each through states S_RLO, S_RMID and S_RHI, then S_CALC
// updates pen and totals before the first row. The row bytes come from
// the font store one per cycle through a shared address adder, and each
// row is held in S_WAIT until the output takes it. The input is not
// ready until the final row of a character has been transferred.
module bitmap_glyph_row_renderer_core import bgr_pkg::*; #(
  parameter int FONT_BYTES       = DEF_FONT_BYTES,
  parameter int MAX_GLYPH_WIDTH  = DEF_MAX_GLYPH_WIDTH,
  parameter int MAX_GLYPH_HEIGHT = DEF_MAX_GLYPH_HEIGHT
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [14:0] font_address, [22:15] font_byte, [30:23] char_code,
  // [31] first_of_text, [47:32] start_x, [63:48] start_y
  input  logic [63:0]  in_tdata,
  // [0] operation
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [15:0] row_x, [31:16] row_y, [63:32] row_bits, [69:64] glyph_width,
  // [93:70] colour, [109:94] text_width, [125:110] text_height, [127:126] 0
  output logic [127:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int CLIP_W = (MAX_GLYPH_WIDTH  < ROW_BITS) ? MAX_GLYPH_WIDTH  : ROW_BITS;
  localparam int CLIP_H = (MAX_GLYPH_HEIGHT < ROW_BITS) ? MAX_GLYPH_HEIGHT : ROW_BITS;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RLO  = 8'b0000_0010,
    S_RMID = 8'b0000_0100,
    S_RHI  = 8'b0000_1000,
    S_CALC = 8'b0001_0000,
    S_ROW  = 8'b0010_0000,
    S_BYTE = 8'b0100_0000,
    S_WAIT = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    F_TAB    = 2'd0,
    F_GLYPH  = 2'd1,
    F_WIDTH  = 2'd2,
    F_HEIGHT = 2'd3
  } fld_t;

  state_t      state_r, state_nxt;
  fld_t        fld_r, fld_nxt;
  addr_t       addr_r, addr_nxt;
  addr_t       base_r, base_nxt;
  logic [6:0]  code_r, code_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic [15:0] w_r, w_nxt;
  logic [15:0] h_r, h_nxt;
  logic [15:0] pen_x_r, pen_x_nxt;
  logic [15:0] pen_y_r, pen_y_nxt;
  logic [15:0] width_total_r, width_total_nxt;
  logic [15:0] height_max_r, height_max_nxt;
  logic [15:0] row_x_r, row_x_nxt;
  logic [15:0] row_y_r, row_y_nxt;
  logic [5:0]  cw_r, cw_nxt;
  logic [5:0]  rows_r, rows_nxt;
  logic [4:0]  row_r, row_nxt;
  logic [12:0] stride_r, stride_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [31:0] bits_r, bits_nxt;
  logic [31:0] out_bits_r, out_bits_nxt;
  logic [3:0]  scale_r, scale_nxt;
  logic [23:0] ink_r, ink_nxt;

  logic        in_acc, out_acc, cfg_wr, mem_wr;
  logic [7:0]  rdata;
  logic [15:0] word, word_pos;
  logic [3:0]  sc;
  addr_t       add_a, add_b, add_sum;
  logic [19:0] wsc, hsc;
  logic [20:0] wtot;
  logic [15:0] hsat;
  logic [2:0]  nbytes;
  logic [31:0] bits_cat, row_mask;
  logic        last_row;
  logic [7:0]  in_code;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign mem_wr  = in_acc && !in_tuser;
  assign in_code = in_tdata[30:23];

  bgr_font_mem #(.FONT_BYTES(FONT_BYTES)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (in_tdata[14:0]),
    .wr_data (in_tdata[22:15]),
    .rd_addr (addr_r),
    .rd_data (rdata)
  );

  bgr_adder u_add (
    .a   (add_a),
    .b   (add_b),
    .sum (add_sum)
  );

  assign sc = (scale_r == 4'd0) ? 4'd1 : ((scale_r > 4'd8) ? 4'd8 : scale_r);

  assign word     = {rdata, lo_r};
  assign word_pos = word[15] ? 16'd0 : word;

  assign wsc  = w_r * sc;
  assign hsc  = h_r * sc;
  assign wtot = {5'd0, width_total_r} + {1'b0, wsc};
  assign hsat = (hsc > 20'hFFFF) ? 16'hFFFF : hsc[15:0];

  assign nbytes   = 3'((7'(cw_r) + 7'd7) >> 3);
  assign bits_cat = bits_r | ({rdata, 24'd0} >> {k_r, 3'b000});
  assign row_mask = ~(32'hFFFF_FFFF >> cw_r);
  assign last_row = ({1'b0, row_r} + 6'd1) == rows_r;

  always_comb begin
    add_a = addr_r;
    add_b = addr_t'(1);
    case (state_r)
      S_RHI: begin
        if (fld_r == F_TAB) begin
          add_a = addr_t'(word);
          add_b = addr_t'({code_r, 1'b0});
        end
      end
      S_WAIT: begin
        add_a = base_r;
        add_b = addr_t'(stride_r);
      end
      default: begin
        add_a = addr_r;
        add_b = addr_t'(1);
      end
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    fld_nxt         = fld_r;
    addr_nxt        = addr_r;
    base_nxt        = base_r;
    code_nxt        = code_r;
    lo_nxt          = lo_r;
    w_nxt           = w_r;
    h_nxt           = h_r;
    pen_x_nxt       = pen_x_r;
    pen_y_nxt       = pen_y_r;
    width_total_nxt = width_total_r;
    height_max_nxt  = height_max_r;
    row_x_nxt       = row_x_r;
    row_y_nxt       = row_y_r;
    cw_nxt          = cw_r;
    rows_nxt        = rows_r;
    row_nxt         = row_r;
    stride_nxt      = stride_r;
    k_nxt           = k_r;
    bits_nxt        = bits_r;
    out_bits_nxt    = out_bits_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_tuser) begin
          if (in_tdata[31]) begin
            pen_x_nxt       = in_tdata[47:32];
            pen_y_nxt       = in_tdata[63:48];
            width_total_nxt = 16'd0;
            height_max_nxt  = 16'd0;
          end
          code_nxt  = (in_code > LAST_PLAIN_CODE) ? FALLBACK_CODE : in_code[6:0];
          addr_nxt  = TABLE_PTR_ADDR;
          fld_nxt   = F_TAB;
          state_nxt = S_RLO;
        end
      end
      S_RLO: begin
        addr_nxt  = add_sum;
        state_nxt = S_RMID;
      end
      S_RMID: begin
        lo_nxt    = rdata;
        state_nxt = S_RHI;
      end
      S_RHI: begin
        case (fld_r)
          F_TAB: begin
            addr_nxt  = add_sum;
            fld_nxt   = F_GLYPH;
            state_nxt = S_RLO;
          end
          F_GLYPH: begin
            addr_nxt  = addr_t'(word);
            fld_nxt   = F_WIDTH;
            state_nxt = S_RLO;
          end
          F_WIDTH: begin
            w_nxt     = word_pos;
            addr_nxt  = add_sum;
            fld_nxt   = F_HEIGHT;
            state_nxt = S_RLO;
          end
          default: begin
            h_nxt     = word_pos;
            state_nxt = S_CALC;
          end
        endcase
      end
      S_CALC: begin
        width_total_nxt = (wtot > 21'h00FFFF) ? 16'hFFFF : wtot[15:0];
        if (hsat > height_max_r) begin
          height_max_nxt = hsat;
        end
        row_x_nxt  = pen_x_r;
        row_y_nxt  = pen_y_r;
        pen_x_nxt  = pen_x_r + wsc[15:0];
        cw_nxt     = (w_r > 16'(CLIP_W)) ? 6'(CLIP_W) : w_r[5:0];
        rows_nxt   = (h_r > 16'(CLIP_H)) ? 6'(CLIP_H) : h_r[5:0];
        stride_nxt = (w_r == 16'd0) ? 13'd1 : 13'(((w_r - 16'd1) >> 3) + 16'd1);
        row_nxt    = 5'd0;
        k_nxt      = 2'd0;
        bits_nxt   = 32'd0;
        addr_nxt   = add_sum;
        base_nxt   = add_sum;
        state_nxt  = (h_r == 16'd0) ? S_IDLE : S_ROW;
      end
      S_ROW: begin
        if (nbytes == 3'd0) begin
          out_bits_nxt = 32'd0;
          state_nxt    = S_WAIT;
        end else begin
          addr_nxt  = add_sum;
          state_nxt = S_BYTE;
        end
      end
      S_BYTE: begin
        addr_nxt = add_sum;
        bits_nxt = bits_cat;
        k_nxt    = k_r + 2'd1;
        if ({1'b0, k_r} == (nbytes - 3'd1)) begin
          out_bits_nxt = bits_cat & row_mask;
          state_nxt    = S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_acc) begin
          if (last_row) begin
            state_nxt = S_IDLE;
          end else begin
            base_nxt  = add_sum;
            addr_nxt  = add_sum;
            row_nxt   = row_r + 5'd1;
            row_y_nxt = row_y_r + 16'(sc);
            k_nxt     = 2'd0;
            bits_nxt  = 32'd0;
            state_nxt = S_ROW;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    scale_nxt = scale_r;
    ink_nxt   = ink_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_SCALE: scale_nxt = cfg_pwdata[3:0];
        REG_INK:   ink_nxt   = cfg_pwdata[23:0];
        default: begin
          scale_nxt = scale_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pen_x_r       <= 16'd0;
      pen_y_r       <= 16'd0;
      width_total_r <= 16'd0;
      height_max_r  <= 16'd0;
      scale_r       <= 4'd1;
      ink_r         <= 24'd0;
    end else begin
      state_r       <= state_nxt;
      pen_x_r       <= pen_x_nxt;
      pen_y_r       <= pen_y_nxt;
      width_total_r <= width_total_nxt;
      height_max_r  <= height_max_nxt;
      scale_r       <= scale_nxt;
      ink_r         <= ink_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fld_r      <= fld_nxt;
    addr_r     <= addr_nxt;
    base_r     <= base_nxt;
    code_r     <= code_nxt;
    lo_r       <= lo_nxt;
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    row_x_r    <= row_x_nxt;
    row_y_r    <= row_y_nxt;
    cw_r       <= cw_nxt;
    rows_r     <= rows_nxt;
    row_r      <= row_nxt;
    stride_r   <= stride_nxt;
    k_r        <= k_nxt;
    bits_r     <= bits_nxt;
    out_bits_r <= out_bits_nxt;
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = state_r == S_WAIT;
  assign out_tlast  = last_row;
  assign out_tdata  = {2'b00, height_max_r, width_total_r, ink_r, cw_r,
                       out_bits_r, row_y_r, row_x_r};

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_INK) ? {8'd0, ink_r} : {28'd0, scale_r};

  `BGR_ASSERT_IMP(a_busy_or_ready, in_tready, !out_tvalid)
  `BGR_ASSERT_IMP(a_row_in_range, out_tvalid, {1'b0, row_r} < rows_r)
  `BGR_ASSERT_NXT(a_more_rows_follow, out_tvalid && out_tready && !out_tlast, !in_tready)
  `BGR_ASSERT_NXT(a_last_frees_input, out_tvalid && out_tready && out_tlast, in_tready)

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import bgr_pkg::*;

  localparam int FONT_BYTES = DEF_FONT_BYTES;
  localparam int DRAW_W = (DEF_MAX_GLYPH_WIDTH < ROW_BITS) ? DEF_MAX_GLYPH_WIDTH : ROW_BITS;
  localparam int MAX_ROWS = 32;
  localparam int DRAW_H = (DEF_MAX_GLYPH_HEIGHT < MAX_ROWS) ? DEF_MAX_GLYPH_HEIGHT : MAX_ROWS;
  localparam int SETTLE_CYCLES = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 450;
  localparam int DIRECTED_TABLE = 16'h0100;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_DRAW  = 1'b1;

  localparam logic [2:0] SCALE_ADDR = {REG_SCALE, 2'b00};
  localparam logic [2:0] INK_ADDR   = {REG_INK, 2'b00};

  typedef struct packed {
    logic        last_row;
    logic [1:0]  pad;
    logic [15:0] text_height;
    logic [15:0] text_width;
    logic [23:0] colour;
    logic [5:0]  glyph_width;
    logic [31:0] row_bits;
    logic [15:0] row_y;
    logic [15:0] row_x;
  } glyph_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [63:0]  in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic         out_tlast;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  glyph_row_t  pending_rows[$];
  bit [7:0]    font_mem [FONT_BYTES];
  bit          font_known [FONT_BYTES];
  logic [15:0] pen_x_m = '0;
  logic [15:0] pen_y_m = '0;
  logic [15:0] width_sum = '0;
  logic [15:0] height_peak = '0;
  logic [3:0]  scale_reg = 4'd1;
  logic [23:0] ink_reg = '0;
  int          fail_count = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  bit          steady_in = 1'b0;

  bitmap_glyph_row_renderer_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] rand_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7FFF;
    return 16'($urandom);
  endfunction

  function automatic int unsigned font_at(int unsigned a);
    return (a >= FONT_BYTES) ? 0 : font_mem[a];
  endfunction

  function automatic int unsigned font_word_at(int unsigned a);
    return font_at(a) | (font_at(a + 1) << 8);
  endfunction

  function automatic bit font_ready_at(int unsigned a);
    return (a >= FONT_BYTES) || font_known[a];
  endfunction

  // bit 15 set means a negative size, taken as zero
  function automatic int unsigned size_field(int unsigned v);
    return (v & 32'h8000) ? 0 : v;
  endfunction

  function automatic int unsigned clip(int unsigned v, int unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic int unsigned plain_code(int unsigned code);
    return (code > LAST_PLAIN_CODE) ? FALLBACK_CODE : code;
  endfunction

  // true when every in-range byte that drawing this code reads has been loaded
  function automatic bit glyph_readable(int unsigned code);
    int unsigned tab, gp, w, h, stride, cw, ch, t, j, i;
    if (!font_ready_at(TABLE_PTR_ADDR) || !font_ready_at(TABLE_PTR_ADDR + 1)) return 0;
    tab = font_word_at(TABLE_PTR_ADDR) + 2 * plain_code(code);
    if (!font_ready_at(tab) || !font_ready_at(tab + 1)) return 0;
    gp = font_word_at(tab);
    for (i = 0; i < 4; i++) if (!font_ready_at(gp + i)) return 0;
    w = size_field(font_word_at(gp));
    h = size_field(font_word_at(gp + 2));
    stride = (w == 0) ? 1 : (w - 1) / 8 + 1;
    cw = clip(w, DRAW_W);
    ch = clip(h, DRAW_H);
    for (t = 0; t < ch; t++)
      for (j = 0; j < (cw + 7) / 8; j++)
        if (!font_ready_at(gp + 4 + t * stride + j)) return 0;
    return 1;
  endfunction

  function automatic int pick_code();
    int i, c;
    for (i = 0; i < 6; i++) begin
      c = $urandom_range(0, 255);
      if (glyph_readable(c)) return c;
    end
    return -1;
  endfunction

  task automatic render_glyph_rows(input logic [7:0] code, input logic first,
                                   input logic [15:0] sx, input logic [15:0] sy);
    int unsigned sc, gp, w, h, stride, cw, ch, tot, base, t, s;
    logic [31:0] bits;
    glyph_row_t r;
    if (first) begin
      pen_x_m = sx;
      pen_y_m = sy;
      width_sum = '0;
      height_peak = '0;
    end
    sc = (scale_reg < 1) ? 1 : (scale_reg > 8) ? 8 : scale_reg;
    gp = font_word_at(font_word_at(TABLE_PTR_ADDR) + 2 * plain_code(code));
    w = size_field(font_word_at(gp));
    h = size_field(font_word_at(gp + 2));
    stride = (w == 0) ? 1 : (w - 1) / 8 + 1;
    tot = width_sum + w * sc;
    width_sum = (tot > 16'hFFFF) ? 16'hFFFF : 16'(tot);
    tot = h * sc;
    if (tot > 16'hFFFF) tot = 16'hFFFF;
    if (tot > height_peak) height_peak = 16'(tot);
    cw = clip(w, DRAW_W);
    ch = clip(h, DRAW_H);
    for (t = 0; t < ch; t++) begin
      bits = '0;
      base = gp + 4 + t * stride;
      for (s = 0; s < cw; s++)
        if (font_at(base + s / 8) & (8'h80 >> (s % 8))) bits[31 - s] = 1'b1;
      r = '0;
      r.row_x = pen_x_m;
      r.row_y = 16'(pen_y_m + t * sc);
      r.row_bits = bits;
      r.glyph_width = cw[5:0];
      r.colour = ink_reg;
      r.text_width = width_sum;
      r.text_height = height_peak;
      r.last_row = (t + 1 == ch);
      pending_rows.push_back(r);
    end
    pen_x_m = 16'(pen_x_m + w * sc);
  endtask

  task automatic send_item(input logic op, input logic [14:0] addr, input logic [7:0] val,
                           input logic [7:0] code, input logic first,
                           input logic [15:0] sx, input logic [15:0] sy);
    int gap;
    gap = steady_in ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {sy, sx, first, code, val, addr};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (op == OP_WRITE) begin
      font_mem[addr] = val;
      font_known[addr] = 1'b1;
    end else begin
      render_glyph_rows(code, first, sx, sy);
    end
  endtask

  // the store only spans FONT_BYTES; bytes above it read as zero
  task automatic put_byte(input int unsigned a, input logic [7:0] v);
    if (a < FONT_BYTES)
      send_item(OP_WRITE, a[14:0], v, 8'($urandom), 1'($urandom), 16'($urandom),
                16'($urandom));
  endtask

  task automatic put_word(input int unsigned a, input logic [15:0] v);
    put_byte(a, v[7:0]);
    put_byte(a + 1, v[15:8]);
  endtask

  task automatic draw_glyph(input int unsigned code, input logic first,
                            input logic [15:0] sx, input logic [15:0] sy);
    if (glyph_readable(code))
      send_item(OP_DRAW, 15'($urandom), 8'($urandom), code[7:0], first, sx, sy);
  endtask

  // rows first, then size words, table entry last
  task automatic define_glyph(input int unsigned code, input int unsigned gaddr,
                              input logic [15:0] w_raw, input logic [15:0] h_raw);
    int unsigned w, h, stride, cw, ch, t, j;
    w = size_field(w_raw);
    h = size_field(h_raw);
    stride = (w == 0) ? 1 : (w - 1) / 8 + 1;
    cw = clip(w, DRAW_W);
    ch = clip(h, DRAW_H);
    for (t = 0; t < ch; t++)
      for (j = 0; j < (cw + 7) / 8; j++)
        put_byte(gaddr + 4 + t * stride + j, 8'($urandom));
    put_word(gaddr, w_raw);
    put_word(gaddr + 2, h_raw);
    put_word(font_word_at(TABLE_PTR_ADDR) + 2 * code, gaddr[15:0]);
  endtask

  task automatic define_random_glyph(input int unsigned code);
    int unsigned w, h, gaddr;
    int d;
    d = $urandom_range(0, 99);
    if (d < 66) begin
      w = $urandom_range(1, 16);
      h = $urandom_range(1, 8);
    end else if (d < 76) begin
      w = $urandom_range(17, 32);
      h = $urandom_range(1, 6);
    end else if (d < 80) begin
      w = $urandom_range(33, 40);
      h = $urandom_range(1, 4);
    end else if (d < 84) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(33, 36);
    end else if (d < 89) begin
      w = $urandom_range(1, 20);
      h = 0;
    end else if (d < 93) begin
      w = 32'h8000 | $urandom_range(0, 32767);
      h = $urandom_range(1, 4);
    end else if (d < 97) begin
      w = $urandom_range(1, 8);
      h = 32'h8000 | $urandom_range(0, 32767);
    end else begin
      w = 0;
      h = $urandom_range(1, 4);
    end
    gaddr = ($urandom_range(0, 29) == 0) ? $urandom_range(32768, 65535)
                                         : $urandom_range(32, 32767);
    define_glyph(code, gaddr, w[15:0], h[15:0]);
  endtask

  task automatic cfg_write(input logic [2:0] a, input logic [31:0] d);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= a;
    cfg_pwdata <= d;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (a == SCALE_ADDR) scale_reg = d[3:0];
    else if (a == INK_ADDR) ink_reg = d[23:0];
    @(posedge clk);
  endtask

  task automatic set_style(input logic [3:0] sc, input logic [23:0] ink);
    cfg_write(SCALE_ADDR, {28'b0, sc});
    cfg_write(INK_ADDR, {8'b0, ink});
  endtask

  // drain all rows, then let a draw with no rows finish
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_fallback_glyph();
    put_word(TABLE_PTR_ADDR, DIRECTED_TABLE);
    define_glyph(FALLBACK_CODE, 32'h0200, 16'd8, 16'd2);
    draw_glyph(FALLBACK_CODE, 1'b1, 16'h8000, 16'h7FFF);
    draw_glyph(200, 1'b0, 16'h0000, 16'h0000);
    draw_glyph(255, 1'b0, 16'hFFFF, 16'hFFFF);
    draw_glyph(128, 1'b1, 16'h7FFF, 16'h8000);
  endtask

  task automatic test_clipping_and_empty();
    // oversize glyph whose rows lie above the store: 32 blank rows
    define_glyph(0, 32'h7FFC, 16'd40, 16'd40);
    draw_glyph(0, 1'b1, 16'h7FF0, 16'h7FF0);
    // glyph pointer above the store: zero size, no rows
    put_word(DIRECTED_TABLE + 2 * LAST_PLAIN_CODE, 16'hFFFF);
    draw_glyph(LAST_PLAIN_CODE, 1'b0, 16'h1234, 16'h5678);
    // huge width, zero height: pen wraps and no rows are drawn
    define_glyph(1, 32'h0300, 16'h7FFF, 16'h0000);
    draw_glyph(1, 1'b0, 16'h0000, 16'h0000);
    // negative width, huge height
    define_glyph(3, 32'h7FF8, 16'h8005, 16'h7FFF);
    draw_glyph(3, 1'b0, 16'h0000, 16'h0000);
    draw_glyph(FALLBACK_CODE, 1'b0, 16'h0000, 16'h0000);
  endtask

  task automatic test_scale_extremes();
    settle();
    set_style(4'd15, 24'hFFFFFF);
    draw_glyph(3, 1'b1, 16'h0100, 16'hFF00);
    draw_glyph(1, 1'b0, 16'h0000, 16'h0000);
    draw_glyph(0, 1'b0, 16'h0000, 16'h0000);
    draw_glyph(FALLBACK_CODE, 1'b0, 16'h0000, 16'h0000);
    settle();
    set_style(4'd0, 24'h5AA5C3);
    draw_glyph(FALLBACK_CODE, 1'b1, 16'hFFF8, 16'h7FFE);
    draw_glyph(200, 1'b0, 16'h0000, 16'h0000);
    draw_glyph(1, 1'b0, 16'h0000, 16'h0000);
  endtask

  task automatic test_random_text();
    int start, phase, c, k, n, i, r;
    logic [3:0] sc;
    logic [23:0] ink;
    start = items_sent;
    phase = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      settle();
      case (phase % 6)
        0: sc = 4'd1;
        1: sc = 4'd8;
        2: sc = 4'd0;
        3: sc = 4'd15;
        4: sc = 4'($urandom_range(2, 7));
        default: sc = 4'($urandom_range(9, 14));
      endcase
      case (phase % 3)
        0: ink = 24'hFFFFFF;
        1: ink = 24'h000000;
        default: ink = 24'($urandom);
      endcase
      set_style(sc, ink);
      phase++;
      steady_in = ($urandom_range(0, 3) == 0);
      repeat (6) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          c = $urandom_range(0, 127);
          define_random_glyph(c);
          if (c == FALLBACK_CODE && $urandom_range(0, 1)) c = $urandom_range(128, 255);
          draw_glyph(c, 1'($urandom), rand_pos(), rand_pos());
          repeat ($urandom_range(0, 3)) begin
            k = pick_code();
            if (k >= 0) draw_glyph(k, ($urandom_range(0, 3) == 0), rand_pos(), rand_pos());
          end
        end else if (r < 80) begin
          n = $urandom_range(2, 6);
          for (i = 0; i < n; i++) begin
            k = pick_code();
            if (k < 0) begin
              k = $urandom_range(0, 127);
              define_random_glyph(k);
            end
            draw_glyph(k, (i == 0), rand_pos(), rand_pos());
          end
        end else if (r < 90) begin
          repeat ($urandom_range(1, 3))
            put_byte($urandom_range(TABLE_PTR_ADDR + 2, FONT_BYTES - 1), 8'($urandom));
        end else if (r < 95) begin
          settle();
        end else begin
          put_word(TABLE_PTR_ADDR, 16'($urandom_range(32, FONT_BYTES - 1)));
        end
      end
    end
    steady_in = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : row_check
    glyph_row_t got;
    glyph_row_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tlast, out_tdata};
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected glyph row: expected none, got %h", $time, got);
        fail_count++;
      end else begin
        want = pending_rows.pop_front();
        check_field("row_x", want.row_x, got.row_x);
        check_field("row_y", want.row_y, got.row_y);
        check_field("row_bits", want.row_bits, got.row_bits);
        check_field("glyph_width", want.glyph_width, got.glyph_width);
        check_field("colour", want.colour, got.colour);
        check_field("text_width", want.text_width, got.text_width);
        check_field("text_height", want.text_height, got.text_height);
        check_field("last_row", want.last_row, got.last_row);
        check_field("pad", want.pad, got.pad);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : row_sink
    int n;
    out_tready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 12);
      out_tready <= 1'b1;
      repeat (n) @(posedge clk);
      n = gap_len();
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_WRITE;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fallback_glyph();
    test_clipping_and_empty();
    test_scale_extremes();
    test_random_text();
    settle();
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/bgr_pkg.sv
design/bgr_font_mem.sv
design/bgr_adder.sv
design/bitmap_glyph_row_renderer_core.sv
dv/tb.sv
